// File: rtl/rkp_pkg.sv
package rkp_pkg;

  localparam int WORD_BITS = 32;

  localparam int MUL_LAT   = 4;
  localparam int DRV_LAT   = 2 * MUL_LAT + 1;
  localparam int HALF_LAT  = MUL_LAT + 1;
  localparam int SUM_LAT   = 3;
  localparam int DIV_STEPS = 8;
  localparam int DIV_BITS  = 64 / DIV_STEPS;
  localparam int DIV_LAT   = DIV_STEPS + 2;

  typedef logic signed [63:0] fx_t;
  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-2:0] step_t;

  typedef struct packed {
    word_t point_x;
    word_t point_y;
  } in_word_t;

  typedef struct packed {
    word_t next_x;
    word_t next_y;
    logic  overflow;
  } out_word_t;

  typedef struct packed {
    logic sat;
    fx_t  v;
  } sres_t;

  localparam int CFG_IDX_BITS = 3;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_STEP_SIZE = 3'd0;
  localparam cfg_idx_t REG_RATE_A    = 3'd1;
  localparam cfg_idx_t REG_RATE_B    = 3'd2;
  localparam cfg_idx_t REG_RATE_D    = 3'd3;
  localparam cfg_idx_t REG_RATE_G    = 3'd4;

  localparam step_t STEP_RESET = step_t'(655);

  localparam fx_t FX_LIM = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SUM_HI = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SUM_LO = 65'sh1_8000_0000_0000_0001;

  localparam fx_t WORD_MAX = {{(65-WORD_BITS){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam fx_t WORD_MIN = ~WORD_MAX;

  function automatic sres_t sadd(fx_t a, fx_t b);
    logic signed [64:0] s;
    sres_t r;
    s = {a[63], a} + {b[63], b};
    r.sat = 1'b0;
    r.v = s[63:0];
    if (s > SUM_HI) begin
      r.sat = 1'b1;
      r.v = FX_LIM;
    end else if (s < SUM_LO) begin
      r.sat = 1'b1;
      r.v = -FX_LIM;
    end
    return r;
  endfunction

  function automatic sres_t ssub(fx_t a, fx_t b);
    return sadd(a, -b);
  endfunction

endpackage

// File: rtl/rkp_dly.sv
module rkp_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      line_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  assign q = line_r[N-1];

endmodule

// File: rtl/rkp_mul.sv
module rkp_mul #(
  parameter int SHIFT = 16
) (
  input  logic         clk,
  input  logic         en,
  input  rkp_pkg::fx_t a,
  input  rkp_pkg::fx_t b,
  output rkp_pkg::fx_t p,
  output logic         sat
);
  import rkp_pkg::*;

  localparam logic [127:0] RND = 128'(1) << (SHIFT - 1);

  logic [63:0]  mx, my, mx_r, my_r;
  logic         n1_r, n2_r, n3_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [127:0] t, t_r;
  logic [63:0]  res, mag;
  logic         ovf;
  logic         sat_nxt, sat_r;
  fx_t          p_nxt, p_r;

  always_comb begin
    mx = a[63] ? 64'(-a) : 64'(a);
    my = b[63] ? 64'(-b) : 64'(b);
  end

  // four 32x32 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      mx_r  <= mx;
      my_r  <= my;
      n1_r  <= a[63] ^ b[63];
      p00_r <= 64'(mx_r[31:0]) * 64'(my_r[31:0]);
      p01_r <= 64'(mx_r[31:0]) * 64'(my_r[63:32]);
      p10_r <= 64'(mx_r[63:32]) * 64'(my_r[31:0]);
      p11_r <= 64'(mx_r[63:32]) * 64'(my_r[63:32]);
      n2_r  <= n1_r;
      t_r   <= t;
      n3_r  <= n2_r;
      p_r   <= p_nxt;
      sat_r <= sat_nxt;
    end
  end

  always_comb begin
    t = {p11_r, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0} + RND;
  end

  always_comb begin
    res = t_r[SHIFT +: 64];
    ovf = (t_r >> (64 + SHIFT)) != '0;
    sat_nxt = ovf | res[63];
    mag = sat_nxt ? 64'(FX_LIM) : res;
    p_nxt = n3_r ? -fx_t'(mag) : fx_t'(mag);
  end

  assign p   = p_r;
  assign sat = sat_r;

endmodule

// File: rtl/rkp_deriv.sv
module rkp_deriv #(
  parameter int FRAC = 16
) (
  input  logic         clk,
  input  logic         en,
  input  rkp_pkg::fx_t rate_a,
  input  rkp_pkg::fx_t rate_b,
  input  rkp_pkg::fx_t rate_d,
  input  rkp_pkg::fx_t rate_g,
  input  rkp_pkg::fx_t xs,
  input  rkp_pkg::fx_t ys,
  input  logic         flag_in,
  output rkp_pkg::fx_t m,
  output rkp_pkg::fx_t k,
  output logic         flag_out
);
  import rkp_pkg::*;

  fx_t          ax, by, dx, gy, dxy, ys_d, ax_d, by_d, gy_d;
  logic         s_ax, s_by, s_dx, s_gy, s_dxy, fl_d, f1, f1_d;
  logic [192:0] bund_d;
  sres_t        sm, sk;
  fx_t          m_r, k_r;
  logic         f_r;

  rkp_mul #(.SHIFT(FRAC)) u_ax (.clk, .en, .a(rate_a), .b(xs), .p(ax), .sat(s_ax));
  rkp_mul #(.SHIFT(FRAC)) u_by (.clk, .en, .a(rate_b), .b(ys), .p(by), .sat(s_by));
  rkp_mul #(.SHIFT(FRAC)) u_dx (.clk, .en, .a(rate_d), .b(xs), .p(dx), .sat(s_dx));
  rkp_mul #(.SHIFT(FRAC)) u_gy (.clk, .en, .a(rate_g), .b(ys), .p(gy), .sat(s_gy));

  rkp_dly #(.W(65), .N(MUL_LAT)) u_ysd (
    .clk, .en, .d({ys, flag_in}), .q({ys_d, fl_d})
  );

  assign f1 = fl_d | s_ax | s_by | s_dx | s_gy;

  rkp_mul #(.SHIFT(FRAC)) u_dxy (.clk, .en, .a(dx), .b(ys_d), .p(dxy), .sat(s_dxy));

  rkp_dly #(.W(193), .N(MUL_LAT)) u_bund (
    .clk, .en, .d({ax, by, gy, f1}), .q(bund_d)
  );

  assign ax_d = bund_d[192:129];
  assign by_d = bund_d[128:65];
  assign gy_d = bund_d[64:1];
  assign f1_d = bund_d[0];

  always_comb begin
    sm = ssub(ax_d, by_d);
    sk = ssub(dxy, gy_d);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= sm.v;
      k_r <= sk.v;
      f_r <= f1_d | s_dxy | sm.sat | sk.sat;
    end
  end

  assign m        = m_r;
  assign k        = k_r;
  assign flag_out = f_r;

endmodule

// File: rtl/rkp_div6.sv
module rkp_div6 (
  input  logic         clk,
  input  logic         en,
  input  rkp_pkg::fx_t v,
  output rkp_pkg::fx_t q
);
  import rkp_pkg::*;

  logic [2:0]  rem_r [DIV_STEPS+1];
  logic [63:0] quo_r [DIV_STEPS+1];
  logic [63:0] dvd_r [DIV_STEPS+1];
  logic        sgn_r [DIV_STEPS+1];
  fx_t         q_r;

  // magnitude plus three gives round half away from zero
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      quo_r[0] <= '0;
      dvd_r[0] <= (v[63] ? 64'(-v) : 64'(v)) + 64'd3;
      sgn_r[0] <= v[63];
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [2:0]  rem_nxt;
    logic [63:0] quo_nxt;

    always_comb begin
      logic [3:0] t;
      rem_nxt = rem_r[s];
      quo_nxt = quo_r[s];
      for (int i = 0; i < DIV_BITS; i++) begin
        t = {rem_nxt, dvd_r[s][63 - s*DIV_BITS - i]};
        if (t >= 4'd6) begin
          rem_nxt = 3'(t - 4'd6);
          quo_nxt[63 - s*DIV_BITS - i] = 1'b1;
        end else begin
          rem_nxt = t[2:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= rem_nxt;
        quo_r[s+1] <= quo_nxt;
        dvd_r[s+1] <= dvd_r[s];
        sgn_r[s+1] <= sgn_r[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= sgn_r[DIV_STEPS] ? -fx_t'(quo_r[DIV_STEPS]) : fx_t'(quo_r[DIV_STEPS]);
    end
  end

  assign q = q_r;

endmodule

// File: rtl/rk4_predator_prey_step.sv
// throughput: one word per cycle; the whole pipeline holds while the output word waits
// the pipeline depth is set by the chained 64-bit multiplies of the four stage evaluations
// reset: synchronous, active low; clears valid bits and loads register reset values
module rk4_predator_prey_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rkp_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rkp_pkg::out_word_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  rkp_pkg::cfg_idx_t   cfg_index,
  input  rkp_pkg::word_t      cfg_data
);
  import rkp_pkg::*;

  localparam int RND_LAT = DRV_LAT + HALF_LAT;
  localparam int SUM_AT  = 4 * DRV_LAT + 3 * HALF_LAT;
  localparam int FIN_LAT = SUM_AT + SUM_LAT + MUL_LAT + DIV_LAT;
  localparam int LAT     = FIN_LAT + 2;

  step_t step_r;
  word_t rate_a_r, rate_b_r, rate_d_r, rate_g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_RESET;
      rate_a_r <= '0;
      rate_b_r <= '0;
      rate_d_r <= '0;
      rate_g_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEP_SIZE: step_r   <= cfg_data[WORD_BITS-2:0];
        REG_RATE_A:    rate_a_r <= cfg_data;
        REG_RATE_B:    rate_b_r <= cfg_data;
        REG_RATE_D:    rate_d_r <= cfg_data;
        REG_RATE_G:    rate_g_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  logic           en;
  logic [LAT-1:0] vld_r;

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  fx_t h, ra, rb, rd, rg, x0, y0;

  assign h  = fx_t'({{(65-WORD_BITS){1'b0}}, step_r});
  assign ra = fx_t'(rate_a_r);
  assign rb = fx_t'(rate_b_r);
  assign rd = fx_t'(rate_d_r);
  assign rg = fx_t'(rate_g_r);
  assign x0 = fx_t'($signed(in_data.point_x));
  assign y0 = fx_t'($signed(in_data.point_y));

  fx_t  dv [4][2];
  logic fe [4];
  fx_t  pt [3][2];
  logic fp [3];

  for (genvar r = 0; r < 4; r++) begin : g_eval
    if (r == 0) begin : g_first
      rkp_deriv #(.FRAC(FRAC_BITS)) u_drv (
        .clk, .en, .rate_a(ra), .rate_b(rb), .rate_d(rd), .rate_g(rg),
        .xs(x0), .ys(y0), .flag_in(1'b0),
        .m(dv[r][0]), .k(dv[r][1]), .flag_out(fe[r])
      );
    end else begin : g_next
      rkp_deriv #(.FRAC(FRAC_BITS)) u_drv (
        .clk, .en, .rate_a(ra), .rate_b(rb), .rate_d(rd), .rate_g(rg),
        .xs(pt[r-1][0]), .ys(pt[r-1][1]), .flag_in(fp[r-1]),
        .m(dv[r][0]), .k(dv[r][1]), .flag_out(fe[r])
      );
    end
  end

  // intermediate points: half step twice, then full step
  for (genvar r = 0; r < 3; r++) begin : g_half
    fx_t          hm [2];
    logic         hs [2];
    logic [127:0] xy_d;
    logic         fd;
    sres_t        sx, sy;

    for (genvar a = 0; a < 2; a++) begin : g_ax
      rkp_mul #(.SHIFT((r == 2) ? FRAC_BITS : FRAC_BITS + 1)) u_hm (
        .clk, .en, .a(h), .b(dv[r][a]), .p(hm[a]), .sat(hs[a])
      );
    end

    rkp_dly #(.W(128), .N((r + 1) * DRV_LAT + r * HALF_LAT + MUL_LAT)) u_xy (
      .clk, .en, .d({x0, y0}), .q(xy_d)
    );

    rkp_dly #(.W(1), .N(MUL_LAT)) u_fl (.clk, .en, .d(fe[r]), .q(fd));

    always_comb begin
      sx = sadd(fx_t'(xy_d[127:64]), hm[0]);
      sy = sadd(fx_t'(xy_d[63:0]), hm[1]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pt[r][0] <= sx.v;
        pt[r][1] <= sy.v;
        fp[r]    <= fd | hs[0] | hs[1] | sx.sat | sy.sat;
      end
    end
  end

  fx_t md [3][2];

  for (genvar r = 0; r < 3; r++) begin : g_mdly
    for (genvar a = 0; a < 2; a++) begin : g_ax
      rkp_dly #(.W(64), .N((3 - r) * RND_LAT)) u_md (
        .clk, .en, .d(dv[r][a]), .q(md[r][a])
      );
    end
  end

  sres_t sa_p [2], sa_q [2], sa_r [2], sb [2], sc [2];
  fx_t   pa_r [2], qa_r [2], ra_r [2], pb_r [2], qb_r [2], s3_r [2];
  logic  fa_r, fb_r, fc_r;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sa_p[a] = sadd(md[0][a], dv[3][a]);
      sa_q[a] = sadd(md[1][a], md[1][a]);
      sa_r[a] = sadd(md[2][a], md[2][a]);
      sb[a]   = sadd(qa_r[a], ra_r[a]);
      sc[a]   = sadd(pb_r[a], qb_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        pa_r[a] <= sa_p[a].v;
        qa_r[a] <= sa_q[a].v;
        ra_r[a] <= sa_r[a].v;
        pb_r[a] <= pa_r[a];
        qb_r[a] <= sb[a].v;
        s3_r[a] <= sc[a].v;
      end
      fa_r <= fe[3] | sa_p[0].sat | sa_q[0].sat | sa_r[0].sat
                    | sa_p[1].sat | sa_q[1].sat | sa_r[1].sat;
      fb_r <= fa_r | sb[0].sat | sb[1].sat;
      fc_r <= fb_r | sc[0].sat | sc[1].sat;
    end
  end

  fx_t  hp [2];
  logic hps [2];
  fx_t  dq [2];
  logic ft, fq;

  for (genvar a = 0; a < 2; a++) begin : g_fin
    rkp_mul #(.SHIFT(FRAC_BITS)) u_hs (
      .clk, .en, .a(h), .b(s3_r[a]), .p(hp[a]), .sat(hps[a])
    );
    rkp_div6 u_div (.clk, .en, .v(hp[a]), .q(dq[a]));
  end

  rkp_dly #(.W(1), .N(MUL_LAT)) u_ft (.clk, .en, .d(fc_r), .q(ft));
  rkp_dly #(.W(1), .N(DIV_LAT)) u_fq (
    .clk, .en, .d(ft | hps[0] | hps[1]), .q(fq)
  );

  logic [127:0] xy_f;

  rkp_dly #(.W(128), .N(FIN_LAT)) u_xyf (.clk, .en, .d({x0, y0}), .q(xy_f));

  sres_t     fs [2];
  fx_t       fin_r [2];
  logic      ff_r;
  word_t     wv [2];
  logic      ws [2];
  out_word_t out_nxt, out_r;

  always_comb begin
    fs[0] = sadd(fx_t'(xy_f[127:64]), dq[0]);
    fs[1] = sadd(fx_t'(xy_f[63:0]), dq[1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r[0] <= fs[0].v;
      fin_r[1] <= fs[1].v;
      ff_r     <= fq | fs[0].sat | fs[1].sat;
    end
  end

  // clamp to the word range
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      ws[a] = 1'b0;
      wv[a] = fin_r[a][WORD_BITS-1:0];
      if (fin_r[a] > WORD_MAX) begin
        ws[a] = 1'b1;
        wv[a] = WORD_MAX[WORD_BITS-1:0];
      end else if (fin_r[a] < WORD_MIN) begin
        ws[a] = 1'b1;
        wv[a] = WORD_MIN[WORD_BITS-1:0];
      end
    end
    out_nxt.next_x   = wv[0];
    out_nxt.next_y   = wv[1];
    out_nxt.overflow = ff_r | ws[0] | ws[1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// File: tb/sv/rk4_predator_prey_step_checker.sv
`timescale 1ns / 100ps

module rk4_predator_prey_step_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  rkp_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  rkp_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  rkp_pkg::cfg_idx_t  cfg_index,
  input  rkp_pkg::word_t     cfg_data,
  output int                 mismatches,
  output int                 pending,
  output int                 checked
);
  import rkp_pkg::*;

  localparam logic [63:0] FX_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  logic [63:0] step_h;
  fx_t rate_a, rate_b, rate_d, rate_g;
  bit clamped;
  out_word_t next_points_q[$];

  function automatic logic [63:0] fx_mag(fx_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic fx_t fx_signed(logic [63:0] m, bit neg);
    logic [63:0] c;
    c = m;
    if (c > FX_MAX) begin
      clamped = 1'b1;
      c = FX_MAX;
    end
    return neg ? -fx_t'(c) : fx_t'(c);
  endfunction

  function automatic fx_t fx_add(fx_t a, fx_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > $signed({1'b0, FX_MAX})) begin
      clamped = 1'b1;
      return fx_t'(FX_MAX);
    end
    if (s < -$signed({1'b0, FX_MAX})) begin
      clamped = 1'b1;
      return -fx_t'(FX_MAX);
    end
    return s[63:0];
  endfunction

  function automatic fx_t fx_mul_shift(fx_t a, fx_t b, int sh);
    logic [127:0] p;
    p = {64'd0, fx_mag(a)} * {64'd0, fx_mag(b)};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > {64'd0, FX_MAX}) begin
      clamped = 1'b1;
      p = {64'd0, FX_MAX};
    end
    return fx_signed(p[63:0], a[63] != b[63]);
  endfunction

  function automatic fx_t fx_mul(fx_t a, fx_t b);
    return fx_mul_shift(a, b, FRAC_BITS);
  endfunction

  function automatic fx_t prey_rate(fx_t x, fx_t y);
    return fx_add(fx_mul(rate_a, x), -fx_mul(rate_b, y));
  endfunction

  function automatic fx_t predator_rate(fx_t x, fx_t y);
    return fx_add(fx_mul(fx_mul(rate_d, x), y), -fx_mul(rate_g, y));
  endfunction

  function automatic word_t to_word(fx_t v);
    if (v > WORD_MAX) begin
      clamped = 1'b1;
      return word_t'(WORD_MAX);
    end
    if (v < WORD_MIN) begin
      clamped = 1'b1;
      return word_t'(WORD_MIN);
    end
    return v[WORD_BITS-1:0];
  endfunction

  function automatic fx_t sixth(fx_t v);
    return fx_signed((fx_mag(v) + 64'd3) / 64'd6, v[63]);
  endfunction

  function automatic out_word_t rk4_next_point(in_word_t p);
    fx_t h, x, y, xs, ys, m1, m2, m3, m4, k1, k2, k3, k4, sx, sy;
    out_word_t r;
    h = fx_t'(step_h);
    x = fx_t'(p.point_x);
    y = fx_t'(p.point_y);
    clamped = 1'b0;
    m1 = prey_rate(x, y);
    k1 = predator_rate(x, y);
    xs = fx_add(x, fx_mul_shift(h, m1, FRAC_BITS + 1));
    ys = fx_add(y, fx_mul_shift(h, k1, FRAC_BITS + 1));
    m2 = prey_rate(xs, ys);
    k2 = predator_rate(xs, ys);
    xs = fx_add(x, fx_mul_shift(h, m2, FRAC_BITS + 1));
    ys = fx_add(y, fx_mul_shift(h, k2, FRAC_BITS + 1));
    m3 = prey_rate(xs, ys);
    k3 = predator_rate(xs, ys);
    xs = fx_add(x, fx_mul(h, m3));
    ys = fx_add(y, fx_mul(h, k3));
    m4 = prey_rate(xs, ys);
    k4 = predator_rate(xs, ys);
    sx = fx_add(fx_add(m1, m4), fx_add(fx_add(m2, m2), fx_add(m3, m3)));
    sy = fx_add(fx_add(k1, k4), fx_add(fx_add(k2, k2), fx_add(k3, k3)));
    r.next_x = to_word(fx_add(x, sixth(fx_mul(h, sx))));
    r.next_y = to_word(fx_add(y, sixth(fx_mul(h, sy))));
    r.overflow = clamped;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at word %0d: %s got %h expected %h", checked, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      step_h = 64'(STEP_RESET);
      rate_a = '0;
      rate_b = '0;
      rate_d = '0;
      rate_g = '0;
      next_points_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEP_SIZE: step_h = 64'(step_t'(cfg_data));
          REG_RATE_A: rate_a = fx_t'(cfg_data);
          REG_RATE_B: rate_b = fx_t'(cfg_data);
          REG_RATE_D: rate_d = fx_t'(cfg_data);
          REG_RATE_G: rate_g = fx_t'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        next_points_q.push_back(rk4_next_point(in_data));
      if (out_valid && out_ready) begin
        if (next_points_q.size() == 0) begin
          report_mismatch("unexpected word next_x", 64'(out_data.next_x), 64'd0);
        end else begin
          want = next_points_q.pop_front();
          if (out_data.next_x !== want.next_x)
            report_mismatch("next_x", 64'(out_data.next_x), 64'(want.next_x));
          if (out_data.next_y !== want.next_y)
            report_mismatch("next_y", 64'(out_data.next_y), 64'(want.next_y));
          if (out_data.overflow !== want.overflow)
            report_mismatch("overflow", 64'(out_data.overflow), 64'(want.overflow));
        end
        checked++;
      end
    end
    pending = next_points_q.size();
  end

  initial begin
    mismatches = 0;
    checked = 0;
    pending = 0;
  end

endmodule

// File: tb/sv/rk4_predator_prey_step_test.sv
`timescale 1ns / 100ps

module rk4_predator_prey_step_test;
  import rkp_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_PHASES = 8;
  localparam int POINTS_PER_PHASE = 200;
  localparam word_t W_MAX = 32'sh7FFF_FFFF;
  localparam word_t W_MIN = 32'sh8000_0000;
  localparam word_t W_ONE = 32'sh0001_0000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_data;
  logic out_valid;
  logic out_ready;
  out_word_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  cfg_idx_t cfg_index;
  word_t cfg_data;
  int mismatches;
  int pending;
  int checked;
  int cycles;
  int sent;
  bit no_idle;
  word_t corner[6];

  rk4_predator_prey_step dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rk4_predator_prey_step_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .checked(checked)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 70)
      return 0;
    if (r < 95)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic word_t rand_value(int small_bits);
    if ($urandom_range(0, 3) == 0)
      return word_t'($urandom);
    return word_t'($signed($urandom_range(0, (1 << small_bits) - 1)) - (1 << (small_bits - 1)));
  endfunction

  initial begin
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      int r, n;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 20);
      end else begin
        out_ready <= 1'b0;
        n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(20, 60);
      end
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_point(word_t x, word_t y);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{point_x: x, point_y: y};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, word_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_model(word_t h, word_t a, word_t b, word_t d, word_t g);
    settle();
    write_reg(REG_STEP_SIZE, h);
    write_reg(REG_RATE_A, a);
    write_reg(REG_RATE_B, b);
    write_reg(REG_RATE_D, d);
    write_reg(REG_RATE_G, g);
  endtask

  task automatic send_corners();
    for (int i = 0; i < 6; i++)
      send_point(corner[i], corner[5 - i]);
  endtask

  initial begin
    corner = '{32'sd0, 32'sd1, -32'sd1, W_ONE, W_MAX, W_MIN};
    cycles = 0;
    sent = 0;
    no_idle = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_STEP_SIZE;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset rates: points pass through unchanged
    send_corners();

    // classic oscillating populations, h = 0.01; top bit of h is masked
    set_model(32'h8000_028F, 32'sh0001_0000, 32'sh0000_8000, 32'sh0000_051F, 32'sh0000_CCCD);
    for (int idx = REG_RATE_G + 1; idx < (1 << CFG_IDX_BITS); idx++)
      write_reg(cfg_idx_t'(idx), W_MAX);
    send_corners();

    set_model(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX);
    send_corners();

    set_model(32'sd0, W_MIN, W_MIN, W_MIN, W_MIN);
    write_reg(REG_STEP_SIZE, W_ONE);
    send_corners();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      no_idle = (ph == 0);
      set_model(($urandom_range(0, 3) == 0) ? word_t'($urandom) : word_t'($urandom_range(0, 4096)),
                rand_value(18), rand_value(18), rand_value(14), rand_value(18));
      for (int i = 0; i < POINTS_PER_PHASE; i++)
        send_point(rand_value(26), rand_value(26));
    end
    no_idle = 0;

    settle();

    $display("sent %0d points over %0d model settings, %0d results checked",
             sent, RANDOM_PHASES + 4, checked);
    if (pending != 0)
      $display("%0d expected results never arrived", pending);
    if (mismatches == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
